### rtl/complex_subspace_rotation_unit_macros.svh
// Assertion macros used by the controller of the complex subspace rotation unit.
`ifndef COMPLEX_SUBSPACE_ROTATION_UNIT_MACROS_SVH
`define COMPLEX_SUBSPACE_ROTATION_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define CSR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define CSR_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CSR_ASSERT_IMP(lbl, ante, cons, msg)
`define CSR_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

### rtl/csr_pkg.sv
// Types and constants of the complex subspace rotation unit.
package csr_pkg;

    localparam int MAX_STATES = 16;
    localparam int IDX_W      = $clog2(MAX_STATES);
    localparam int ADDR_W     = 2 * IDX_W;
    localparam int DEPTH      = MAX_STATES * MAX_STATES;
    localparam int CFG_W      = 5;
    localparam int COEF_W     = 18;
    localparam int SAMP_W     = 24;
    localparam int OUT_W      = 24;
    localparam int PROD_W     = COEF_W + SAMP_W;
    localparam int ACC_W      = 48;
    localparam int FRAC_W     = 16;
    localparam int Q_W        = ACC_W - FRAC_W;
    localparam int RESULT_CAP = (MAX_STATES < 16) ? MAX_STATES : 16;

    localparam logic [CFG_W-1:0] STATE_COUNT_RESET = CFG_W'(16);

    localparam logic KIND_LOAD   = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } csr_state_t;

    typedef struct packed {
        logic             accept;
        logic             rd_en;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic             first_col;
        logic             last_col;
        logic             last_row;
    } csr_cmd_t;

    typedef struct packed {
        logic done;
    } csr_stat_t;

endpackage

### rtl/csr_ctrl.sv
// Controller: request acceptance, configuration register and row/column sequencing.
`include "complex_subspace_rotation_unit_macros.svh"

module csr_ctrl
    import csr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              kind,
    input  logic              last_sample,
    output logic              busy,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CFG_W-1:0]  cfg_data,
    output csr_cmd_t          cmd,
    input  csr_stat_t         stat
);

    csr_state_t       state_reg, state_next;
    logic [IDX_W-1:0] row_reg, row_next;
    logic [IDX_W-1:0] col_reg, col_next;
    logic [CFG_W-1:0] state_count_reg, state_count_next;
    logic [CFG_W-1:0] n_eff;
    logic [IDX_W-1:0] n_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            row_reg         <= '0;
            col_reg         <= '0;
            state_count_reg <= STATE_COUNT_RESET;
        end
        else
        begin
            state_reg       <= state_next;
            row_reg         <= row_next;
            col_reg         <= col_next;
            state_count_reg <= state_count_next;
        end
    end

    // clamp the state count to 1..RESULT_CAP
    always_comb
    begin
        if (state_count_reg == '0)
            n_eff = CFG_W'(1);
        else if (state_count_reg > CFG_W'(RESULT_CAP))
            n_eff = CFG_W'(RESULT_CAP);
        else
            n_eff = state_count_reg;
        n_last = IDX_W'(n_eff - CFG_W'(1));
    end

    always_comb
    begin
        state_next       = state_reg;
        row_next         = row_reg;
        col_next         = col_reg;
        state_count_next = state_count_reg;
        busy             = (state_reg != ST_IDLE);
        cfg_ready        = (state_reg == ST_IDLE);

        cmd.accept    = start && (state_reg == ST_IDLE);
        cmd.rd_en     = 1'b0;
        cmd.row       = row_reg;
        cmd.col       = col_reg;
        cmd.first_col = (col_reg == '0);
        cmd.last_col  = (col_reg == n_last);
        cmd.last_row  = (row_reg == n_last);

        if (cfg_valid && cfg_ready)
            state_count_next = cfg_data;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.accept && (kind == KIND_SAMPLE) && last_sample)
                begin
                    state_next = ST_RUN;
                    row_next   = '0;
                    col_next   = '0;
                end
            end
            ST_RUN:
            begin
                cmd.rd_en = 1'b1;
                if (cmd.last_col)
                begin
                    col_next = '0;
                    if (cmd.last_row)
                        state_next = ST_DRAIN;
                    else
                        row_next = row_reg + IDX_W'(1);
                end
                else
                    col_next = col_reg + IDX_W'(1);
            end
            ST_DRAIN:
            begin
                // hold until the final result leaves the pipeline
                if (stat.done)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `CSR_ASSERT_NXT(a_run_on_last, start && !busy && kind == KIND_SAMPLE && last_sample, state_reg == ST_RUN, "last sample did not start a run")
    `CSR_ASSERT_IMP(a_col_in_range, state_reg == ST_RUN, col_reg <= n_last && row_reg <= n_last, "row or column beyond state count")
    `CSR_ASSERT_IMP(a_done_in_drain, stat.done, state_reg == ST_DRAIN, "final result outside drain")

endmodule

### rtl/csr_datapath.sv
// Datapath: coefficient and sample memories, complex MAC pipeline, rounding and saturation.
module csr_datapath
    import csr_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  csr_cmd_t                 cmd,
    output csr_stat_t                stat,
    input  logic                     kind,
    input  logic [IDX_W-1:0]         row_index,
    input  logic [IDX_W-1:0]         col_index,
    input  logic signed [COEF_W-1:0] coeff_re,
    input  logic signed [COEF_W-1:0] coeff_im,
    input  logic signed [SAMP_W-1:0] sample_re,
    input  logic signed [SAMP_W-1:0] sample_im,
    output logic                     result_valid,
    output logic [IDX_W-1:0]         state_index,
    output logic signed [OUT_W-1:0]  out_re,
    output logic signed [OUT_W-1:0]  out_im,
    output logic                     saturated,
    output logic                     last
);

    localparam logic signed [Q_W-1:0] OUT_MAX = Q_W'((2 ** (OUT_W - 1)) - 1);
    localparam logic signed [Q_W-1:0] OUT_MIN = -Q_W'(2 ** (OUT_W - 1));
    localparam logic signed [ACC_W-1:0] HALF  = ACC_W'(2 ** (FRAC_W - 1));

    logic signed [COEF_W-1:0] coef_re_mem [DEPTH];
    logic signed [COEF_W-1:0] coef_im_mem [DEPTH];
    logic signed [SAMP_W-1:0] samp_re_mem [MAX_STATES];
    logic signed [SAMP_W-1:0] samp_im_mem [MAX_STATES];

    // stage 1: memory read
    logic signed [COEF_W-1:0] cr_reg, ci_reg;
    logic signed [SAMP_W-1:0] sr_reg, si_reg;
    logic                     s1_valid_reg, s1_first_reg, s1_lastc_reg, s1_lastr_reg;
    logic [IDX_W-1:0]         s1_row_reg;
    // stage 2: products
    logic signed [PROD_W-1:0] p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg;
    logic                     s2_valid_reg, s2_first_reg, s2_lastc_reg, s2_lastr_reg;
    logic [IDX_W-1:0]         s2_row_reg;
    // stage 3: accumulation
    logic signed [ACC_W-1:0]  acc_re_reg, acc_im_reg, acc_re_next, acc_im_next;
    logic                     s3_valid_reg, s3_lastc_reg, s3_lastr_reg;
    logic [IDX_W-1:0]         s3_row_reg;
    // stage 4: result
    logic signed [Q_W-1:0]    q_re, q_im;
    logic signed [OUT_W-1:0]  sat_re, sat_im;
    logic                     clip_re, clip_im;
    logic                     result_valid_reg, last_reg, saturated_reg;
    logic [IDX_W-1:0]         state_index_reg;
    logic signed [OUT_W-1:0]  out_re_reg, out_im_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.accept && kind == KIND_LOAD)
        begin
            coef_re_mem[{row_index, col_index}] <= coeff_re;
            coef_im_mem[{row_index, col_index}] <= coeff_im;
        end
        if (cmd.accept && kind == KIND_SAMPLE)
        begin
            samp_re_mem[col_index] <= sample_re;
            samp_im_mem[col_index] <= sample_im;
        end
        if (cmd.rd_en)
        begin
            cr_reg <= coef_re_mem[{cmd.row, cmd.col}];
            ci_reg <= coef_im_mem[{cmd.row, cmd.col}];
            sr_reg <= samp_re_mem[cmd.col];
            si_reg <= samp_im_mem[cmd.col];
        end
    end

    always_comb
    begin
        acc_re_next = (s2_first_reg ? '0 : acc_re_reg) + ACC_W'(p_rr_reg) - ACC_W'(p_ii_reg);
        acc_im_next = (s2_first_reg ? '0 : acc_im_reg) + ACC_W'(p_ri_reg) + ACC_W'(p_ir_reg);
    end

    // round half up, then clip to the output range
    always_comb
    begin
        q_re    = Q_W'((acc_re_reg + HALF) >>> FRAC_W);
        q_im    = Q_W'((acc_im_reg + HALF) >>> FRAC_W);
        clip_re = (q_re > OUT_MAX) || (q_re < OUT_MIN);
        clip_im = (q_im > OUT_MAX) || (q_im < OUT_MIN);
        if (q_re > OUT_MAX)
            sat_re = OUT_W'(OUT_MAX);
        else if (q_re < OUT_MIN)
            sat_re = OUT_W'(OUT_MIN);
        else
            sat_re = OUT_W'(q_re);
        if (q_im > OUT_MAX)
            sat_im = OUT_W'(OUT_MAX);
        else if (q_im < OUT_MIN)
            sat_im = OUT_W'(OUT_MIN);
        else
            sat_im = OUT_W'(q_im);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            s3_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
            last_reg         <= 1'b0;
        end
        else
        begin
            s1_valid_reg     <= cmd.rd_en;
            s2_valid_reg     <= s1_valid_reg;
            s3_valid_reg     <= s2_valid_reg;
            result_valid_reg <= s3_valid_reg && s3_lastc_reg;
            last_reg         <= s3_valid_reg && s3_lastc_reg && s3_lastr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_first_reg <= cmd.first_col;
        s1_lastc_reg <= cmd.last_col;
        s1_lastr_reg <= cmd.last_row;
        s1_row_reg   <= cmd.row;

        p_rr_reg     <= cr_reg * sr_reg;
        p_ii_reg     <= ci_reg * si_reg;
        p_ri_reg     <= cr_reg * si_reg;
        p_ir_reg     <= ci_reg * sr_reg;
        s2_first_reg <= s1_first_reg;
        s2_lastc_reg <= s1_lastc_reg;
        s2_lastr_reg <= s1_lastr_reg;
        s2_row_reg   <= s1_row_reg;

        if (s2_valid_reg)
        begin
            acc_re_reg <= acc_re_next;
            acc_im_reg <= acc_im_next;
        end
        s3_lastc_reg <= s2_lastc_reg;
        s3_lastr_reg <= s2_lastr_reg;
        s3_row_reg   <= s2_row_reg;

        state_index_reg <= s3_row_reg;
        out_re_reg      <= sat_re;
        out_im_reg      <= sat_im;
        saturated_reg   <= clip_re || clip_im;
    end

    assign stat.done    = result_valid_reg && last_reg;
    assign result_valid = result_valid_reg;
    assign state_index  = state_index_reg;
    assign out_re       = out_re_reg;
    assign out_im       = out_im_reg;
    assign saturated    = saturated_reg;
    assign last         = result_valid_reg && last_reg;

endmodule

### rtl/complex_subspace_rotation_unit.sv
// Complex subspace rotation unit: stored complex matrix times buffered sample vector.
//
// Requests enter on start while busy is low. A request with kind 0 writes one Q1.16
// coefficient at (row_index, col_index); kind 1 writes one sample at col_index. Both
// leave busy low, so such requests can follow every cycle.
// A sample request with last_sample set raises busy and runs the product: for each
// row r below the state count the unit emits out = sum_c A[r][c] * x[c], rounded half
// up and clipped to 24 bits, with saturated flagging a clip and last on the final row.
// One complex multiply-accumulate per cycle through a single four-multiplier MAC:
// a run over n states steps through the matrix row by row, column by column, and holds
// busy until the result of the final row has left the pipeline; each row yields one result.
// Each result shows on the result ports for one cycle, marked by result_valid; the
// receiver cannot stall it.
// The state count is written through cfg_valid/cfg_ready/cfg_data while busy is low;
// 0 acts as 1 and values above 16 act as 16.
// Reset (rst_n low) returns to idle with a state count of 16; matrix and sample
// memories are not cleared and must be written before use.
module complex_subspace_rotation_unit
    import csr_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic                     kind,
    input  logic [IDX_W-1:0]         row_index,
    input  logic [IDX_W-1:0]         col_index,
    input  logic signed [COEF_W-1:0] coeff_re,
    input  logic signed [COEF_W-1:0] coeff_im,
    input  logic signed [SAMP_W-1:0] sample_re,
    input  logic signed [SAMP_W-1:0] sample_im,
    input  logic                     last_sample,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_W-1:0]         cfg_data,
    output logic                     result_valid,
    output logic [IDX_W-1:0]         state_index,
    output logic signed [OUT_W-1:0]  out_re,
    output logic signed [OUT_W-1:0]  out_im,
    output logic                     saturated,
    output logic                     last
);

    csr_cmd_t  cmd;
    csr_stat_t stat;

    csr_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .kind        (kind),
        .last_sample (last_sample),
        .busy        (busy),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .cmd         (cmd),
        .stat        (stat)
    );

    csr_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .kind         (kind),
        .row_index    (row_index),
        .col_index    (col_index),
        .coeff_re     (coeff_re),
        .coeff_im     (coeff_im),
        .sample_re    (sample_re),
        .sample_im    (sample_im),
        .result_valid (result_valid),
        .state_index  (state_index),
        .out_re       (out_re),
        .out_im       (out_im),
        .saturated    (saturated),
        .last         (last)
    );

endmodule

### test/tb_complex_subspace_rotation_unit.sv
// Self-checking testbench for the complex subspace rotation unit.
module tb_complex_subspace_rotation_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import csr_pkg::*;

    localparam int     CLK_PERIOD     = 20;
    localparam int     RESET_CYCLES   = 11;
    localparam int     RANDOM_ITEMS   = 180;
    localparam int     PHASE_ITEMS    = 24;
    localparam int     CALM_TAIL      = 60;
    localparam int     DRAIN_CYCLES   = 300;
    localparam int     WATCHDOG_LIMIT = 2000;
    localparam int     DIR_N          = 20;
    localparam int     PLAN_N         = 10;
    localparam longint COEF_MAX       = (longint'(1) << (COEF_W - 1)) - 1;
    localparam longint COEF_MIN       = -(longint'(1) << (COEF_W - 1));
    localparam longint SAMP_MAX       = (longint'(1) << (SAMP_W - 1)) - 1;
    localparam longint SAMP_MIN       = -(longint'(1) << (SAMP_W - 1));
    localparam longint OUT_MAX        = (longint'(1) << (OUT_W - 1)) - 1;
    localparam longint OUT_MIN        = -(longint'(1) << (OUT_W - 1));

    typedef struct packed {
        logic                     kind;
        logic [IDX_W-1:0]         row;
        logic [IDX_W-1:0]         col;
        logic signed [COEF_W-1:0] cre;
        logic signed [COEF_W-1:0] cim;
        logic signed [SAMP_W-1:0] sre;
        logic signed [SAMP_W-1:0] sim;
        logic                     lst;
    } rot_req_t;

    typedef struct packed {
        logic [IDX_W-1:0]        idx;
        logic signed [OUT_W-1:0] re;
        logic signed [OUT_W-1:0] im;
        logic                    sat;
        logic                    lst;
    } rot_result_t;

    typedef struct packed {
        rot_req_t    rq;
        logic        typed;
        rot_result_t res;
    } dir_row_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     start = 1'b0;
    logic                     busy;
    logic                     kind = 1'b0;
    logic [IDX_W-1:0]         row_index = '0;
    logic [IDX_W-1:0]         col_index = '0;
    logic signed [COEF_W-1:0] coeff_re = '0;
    logic signed [COEF_W-1:0] coeff_im = '0;
    logic signed [SAMP_W-1:0] sample_re = '0;
    logic signed [SAMP_W-1:0] sample_im = '0;
    logic                     last_sample = 1'b0;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_W-1:0]         cfg_data = '0;
    logic                     result_valid;
    logic [IDX_W-1:0]         state_index;
    logic signed [OUT_W-1:0]  out_re;
    logic signed [OUT_W-1:0]  out_im;
    logic                     saturated;
    logic                     last;

    // predictor state
    logic signed [COEF_W-1:0] coef_re_mem [DEPTH];
    logic signed [COEF_W-1:0] coef_im_mem [DEPTH];
    logic signed [SAMP_W-1:0] samp_re_mem [MAX_STATES];
    logic signed [SAMP_W-1:0] samp_im_mem [MAX_STATES];
    logic [CFG_W-1:0]         state_count_reg = STATE_COUNT_RESET;
    rot_result_t              pending_rotations [$];

    dir_row_t         dir_tab [DIR_N];
    logic [CFG_W-1:0] cfg_plan [PLAN_N] = '{5'd0, 5'd31, 5'd2, 5'd17, 5'd16,
                                            5'd5, 5'd1, 5'd9, 5'd3, 5'd12};

    int errors        = 0;
    int req_count     = 0;
    int rand_items    = 0;
    int results_seen  = 0;
    int cfg_writes    = 0;
    int idle_cycles   = 0;
    int idle_rate     = 1;
    bit no_idle       = 1'b0;

    complex_subspace_rotation_unit uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .kind         (kind),
        .row_index    (row_index),
        .col_index    (col_index),
        .coeff_re     (coeff_re),
        .coeff_im     (coeff_im),
        .sample_re    (sample_re),
        .sample_im    (sample_im),
        .last_sample  (last_sample),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .state_index  (state_index),
        .out_re       (out_re),
        .out_im       (out_im),
        .saturated    (saturated),
        .last         (last)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic int eff_states(input logic [CFG_W-1:0] v);
        if (v == 0)
            return 1;
        if (int'(v) > RESULT_CAP)
            return RESULT_CAP;
        return int'(v);
    endfunction

    // round half up from Q.16, then clip to the output width
    function automatic logic signed [OUT_W-1:0] round_clip(input longint acc, inout bit sat);
        longint q;
        q = (acc + 64'sd32768) >>> FRAC_W;
        if (q > OUT_MAX)
        begin
            sat = 1'b1;
            return OUT_W'(OUT_MAX);
        end
        if (q < OUT_MIN)
        begin
            sat = 1'b1;
            return OUT_W'(OUT_MIN);
        end
        return OUT_W'(q);
    endfunction

    task automatic apply_request(input rot_req_t rq, input bit emit);
        int          n;
        int          addr;
        longint      acc_re;
        longint      acc_im;
        bit          sat;
        rot_result_t res;
        if (rq.kind == KIND_LOAD)
        begin
            addr = int'(rq.row) * MAX_STATES + int'(rq.col);
            coef_re_mem[addr] = rq.cre;
            coef_im_mem[addr] = rq.cim;
            return;
        end
        samp_re_mem[rq.col] = rq.sre;
        samp_im_mem[rq.col] = rq.sim;
        if (!rq.lst || !emit)
            return;
        n = eff_states(state_count_reg);
        for (int r = 0; r < n; r++)
        begin
            acc_re = 0;
            acc_im = 0;
            sat = 1'b0;
            for (int c = 0; c < n; c++)
            begin
                addr = r * MAX_STATES + c;
                acc_re += longint'(coef_re_mem[addr]) * longint'(samp_re_mem[c])
                        - longint'(coef_im_mem[addr]) * longint'(samp_im_mem[c]);
                acc_im += longint'(coef_re_mem[addr]) * longint'(samp_im_mem[c])
                        + longint'(coef_im_mem[addr]) * longint'(samp_re_mem[c]);
            end
            res.idx = IDX_W'(r);
            res.re  = round_clip(acc_re, sat);
            res.im  = round_clip(acc_im, sat);
            res.sat = sat;
            res.lst = (r == n - 1);
            pending_rotations.push_back(res);
        end
    endtask

    function automatic logic signed [COEF_W-1:0] rand_coeff();
        case ($urandom_range(0, 3))
            0:       return COEF_W'($urandom);
            1:       return COEF_W'(int'($urandom_range(0, 8192)) - 4096);
            2:       return COEF_W'(int'($urandom_range(0, 512)) - 256);
            default:
            begin
                case ($urandom_range(0, 3))
                    0:       return COEF_W'(COEF_MIN);
                    1:       return COEF_W'(COEF_MAX);
                    2:       return COEF_W'(-1);
                    default: return '0;
                endcase
            end
        endcase
    endfunction

    function automatic logic signed [SAMP_W-1:0] rand_sample();
        case ($urandom_range(0, 3))
            0:       return SAMP_W'($urandom);
            1:       return SAMP_W'(int'($urandom_range(0, 131072)) - 65536);
            2:       return SAMP_W'(int'($urandom_range(0, 2048)) - 1024);
            default:
            begin
                case ($urandom_range(0, 3))
                    0:       return SAMP_W'(SAMP_MIN);
                    1:       return SAMP_W'(SAMP_MAX);
                    2:       return SAMP_W'(-1);
                    default: return '0;
                endcase
            end
        endcase
    endfunction

    function automatic rot_req_t make_request(input logic k, input int row, input int col,
                                              input logic lst);
        rot_req_t rq;
        rq.kind = k;
        rq.row  = IDX_W'(row);
        rq.col  = IDX_W'(col);
        rq.cre  = rand_coeff();
        rq.cim  = rand_coeff();
        rq.sre  = rand_sample();
        rq.sim  = rand_sample();
        rq.lst  = lst;
        return rq;
    endfunction

    function automatic dir_row_t mk_row(input logic k, input int row, input int col,
                                        input int cre, input int cim, input int sre,
                                        input int sim, input logic lst, input logic typed,
                                        input int xre, input int xim, input logic xsat);
        dir_row_t d;
        d.rq.kind = k;
        d.rq.row  = IDX_W'(row);
        d.rq.col  = IDX_W'(col);
        d.rq.cre  = COEF_W'(cre);
        d.rq.cim  = COEF_W'(cim);
        d.rq.sre  = SAMP_W'(sre);
        d.rq.sim  = SAMP_W'(sim);
        d.rq.lst  = lst;
        d.typed   = typed;
        d.res.idx = '0;
        d.res.re  = OUT_W'(xre);
        d.res.im  = OUT_W'(xim);
        d.res.sat = xsat;
        d.res.lst = 1'b1;
        return d;
    endfunction

    task automatic report_mismatch(input string msg);
        errors++;
        $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    // drop start for a random burst now and then
    task automatic pace();
        if (!no_idle && idle_rate != 0 && $urandom_range(0, 4 * idle_rate) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
    endtask

    // Present one request and hold it until the unit takes it. Start stays high on
    // return; the caller drops it or presents the next request.
    task automatic send(input rot_req_t rq, input bit typed, input rot_result_t typed_res);
        pace();
        start       <= 1'b1;
        kind        <= rq.kind;
        row_index   <= rq.row;
        col_index   <= rq.col;
        coeff_re    <= rq.cre;
        coeff_im    <= rq.cim;
        sample_re   <= rq.sre;
        sample_im   <= rq.sim;
        last_sample <= rq.lst;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (typed)
        begin
            apply_request(rq, 1'b0);
            pending_rotations.push_back(typed_res);
        end
        else
            apply_request(rq, 1'b1);
        req_count++;
    endtask

    task automatic wait_idle();
        while (pending_rotations.size() != 0)
            @(posedge clk);
        while (busy)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_state_count(input logic [CFG_W-1:0] v);
        wait_idle();
        if (!no_idle && idle_rate != 0)
            repeat ($urandom_range(1, 17)) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        state_count_reg = v;
        cfg_writes++;
        cfg_valid <= 1'b0;
    endtask

    // Coefficient loads, optional stray sample, then a shuffled sample vector ending
    // in the trigger; now and then the trigger comes early.
    task automatic grid_point(input int n);
        int perm [MAX_STATES];
        int loads;
        int stop;
        int j;
        int tmp;
        loads = $urandom_range(0, 4);
        for (int i = 0; i < loads; i++)
        begin
            send(make_request(KIND_LOAD, $urandom_range(0, 15), $urandom_range(0, 15),
                              1'($urandom_range(0, 1))), 1'b0, '0);
            rand_items++;
        end
        if ($urandom_range(0, 7) == 0)
        begin
            send(make_request(KIND_SAMPLE, $urandom_range(0, 15), $urandom_range(0, 15),
                              1'b0), 1'b0, '0);
            rand_items++;
        end
        for (int i = 0; i < MAX_STATES; i++)
            perm[i] = i;
        for (int i = n - 1; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            tmp = perm[i];
            perm[i] = perm[j];
            perm[j] = tmp;
        end
        stop = ($urandom_range(0, 9) == 0) ? $urandom_range(0, n - 1) : n - 1;
        for (int i = 0; i <= stop; i++)
        begin
            send(make_request(KIND_SAMPLE, $urandom_range(0, 15), perm[i], i == stop),
                 1'b0, '0);
            rand_items++;
        end
    endtask

    always @(posedge clk)
    begin : check_results
        rot_result_t want;
        if (rst_n && result_valid)
        begin
            results_seen++;
            if (pending_rotations.size() == 0)
                report_mismatch($sformatf("result for state %0d with nothing expected",
                                          state_index));
            else
            begin
                want = pending_rotations.pop_front();
                if (state_index !== want.idx)
                    report_mismatch($sformatf("state_index got %0d expected %0d",
                                              state_index, want.idx));
                if (out_re !== want.re)
                    report_mismatch($sformatf("out_re of state %0d got %0d expected %0d",
                                              want.idx, out_re, want.re));
                if (out_im !== want.im)
                    report_mismatch($sformatf("out_im of state %0d got %0d expected %0d",
                                              want.idx, out_im, want.im));
                if (saturated !== want.sat)
                    report_mismatch($sformatf("saturated of state %0d got %0b expected %0b",
                                              want.idx, saturated, want.sat));
                if (last !== want.lst)
                    report_mismatch($sformatf("last of state %0d got %0b expected %0b",
                                              want.idx, last, want.lst));
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && ((start && !busy) || result_valid || (cfg_valid && cfg_ready)))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[%0t] watchdog: no progress for %0d cycles", $realtime, idle_cycles);
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        int phase;
        int budget;

        // single-state runs: only A[0][0] and x[0] feed the result
        dir_tab[0]  = mk_row(KIND_LOAD,   0,  0,  65536,       0,        0,        0, 1, 0,
                             0, 0, 0);
        dir_tab[1]  = mk_row(KIND_SAMPLE, 0,  0,      0,       0,  8388607, -8388608, 1, 1,
                             8388607, -8388608, 0);
        dir_tab[2]  = mk_row(KIND_LOAD,   0,  0, -131072,      0,        0,        0, 0, 0,
                             0, 0, 0);
        dir_tab[3]  = mk_row(KIND_SAMPLE, 0,  0,      0,       0, -8388608,        0, 1, 1,
                             8388607, 0, 1);
        dir_tab[4]  = mk_row(KIND_SAMPLE, 0,  0,      0,       0,  8388607,  8388607, 1, 1,
                             -8388608, -8388608, 1);
        dir_tab[5]  = mk_row(KIND_LOAD,   0,  0,      0,  131071,        0,        0, 0, 0,
                             0, 0, 0);
        dir_tab[6]  = mk_row(KIND_SAMPLE, 0,  0,      0,       0,        1,        0, 1, 1,
                             0, 2, 0);
        dir_tab[7]  = mk_row(KIND_LOAD,   0,  0,  32768,       0,        0,        0, 0, 0,
                             0, 0, 0);
        dir_tab[8]  = mk_row(KIND_SAMPLE, 0,  0,      0,       0,        1,       -1, 1, 1,
                             1, 0, 0);
        dir_tab[9]  = mk_row(KIND_SAMPLE, 0,  0,      0,       0,        3,       -3, 1, 1,
                             2, -1, 0);
        dir_tab[10] = mk_row(KIND_LOAD,   0,  0, 131071, -131072,        0,        0, 0, 0,
                             0, 0, 0);
        dir_tab[11] = mk_row(KIND_SAMPLE, 0,  0,      0,       0,        0,        0, 1, 1,
                             0, 0, 0);
        dir_tab[12] = mk_row(KIND_SAMPLE, 0,  5,      0,       0,       -1,        1, 0, 0,
                             0, 0, 0);
        dir_tab[13] = mk_row(KIND_LOAD,  15, 15, -131072, 131071,  8388607, -8388608, 1, 0,
                             0, 0, 0);
        dir_tab[14] = mk_row(KIND_LOAD,   0, 15, 131071,  131071,        0,        0, 0, 0,
                             0, 0, 0);
        dir_tab[15] = mk_row(KIND_SAMPLE, 15, 15, -1,          -1,  8388607, -8388608, 0, 0,
                             0, 0, 0);
        dir_tab[16] = mk_row(KIND_SAMPLE, 0,  0,      0,       0, -8388608,  8388607, 1, 0,
                             0, 0, 0);
        dir_tab[17] = mk_row(KIND_LOAD,   0,  0,     -1,      -1,        0,        0, 0, 0,
                             0, 0, 0);
        dir_tab[18] = mk_row(KIND_SAMPLE, 0,  0,      0,       0, -8388608, -8388608, 1, 0,
                             0, 0, 0);
        dir_tab[19] = mk_row(KIND_SAMPLE, 7, 10,      0,       0,   123456,  -654321, 1, 0,
                             0, 0, 0);

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill every coefficient and sample once, then run at the reset state count
        for (int r = 0; r < MAX_STATES; r++)
            for (int c = 0; c < MAX_STATES; c++)
                send(make_request(KIND_LOAD, r, c, 1'($urandom_range(0, 1))), 1'b0, '0);
        for (int c = 0; c < MAX_STATES; c++)
            send(make_request(KIND_SAMPLE, $urandom_range(0, 15), c, c == MAX_STATES - 1),
                 1'b0, '0);
        start <= 1'b0;

        write_state_count(5'd1);
        for (int i = 0; i < DIR_N; i++)
            send(dir_tab[i].rq, dir_tab[i].typed, dir_tab[i].res);
        start <= 1'b0;

        phase = 0;
        while (rand_items < RANDOM_ITEMS)
        begin
            write_state_count((phase < PLAN_N) ? cfg_plan[phase]
                                               : CFG_W'($urandom_range(0, 31)));
            idle_rate = $urandom_range(0, 2);
            budget = rand_items + PHASE_ITEMS;
            while (rand_items < budget && rand_items < RANDOM_ITEMS)
            begin
                grid_point(eff_states(state_count_reg));
                no_idle = (rand_items >= RANDOM_ITEMS - CALM_TAIL);
            end
            start <= 1'b0;
            phase++;
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_rotations.size() != 0)
            report_mismatch($sformatf("%0d expected results never arrived",
                                      pending_rotations.size()));

        $display("Sent %0d requests (%0d random) under %0d state count settings",
                 req_count, rand_items, cfg_writes);
        $display("Checked %0d rotated states, %0d mismatches", results_seen, errors);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
